[rtl/vlw_pkg.sv]
// vlw_pkg: widths, constants and controller/datapath structs for the voxel line walker
// standalone package, no dependencies
package vlw_pkg;

	localparam int XY_W = 9;
	localparam int Z_W = 6;
	localparam int MAP_SIDE = 512;
	localparam int MAP_HEIGHT = 64;

	localparam int INC_W = 22;
	localparam int ACC_W = 24;

	// major axis increment is 1 << MAJ_SHIFT
	localparam int MAJ_SHIFT = 10;
	localparam logic [INC_W-1:0] MAJ_INC = INC_W'(1 << MAJ_SHIFT);
	localparam logic [INC_W-1:0] ZERO_INC = INC_W'(32'h3fffffff / MAP_SIDE);

	// divider operands
	localparam int DVD_W = XY_W + MAJ_SHIFT;
	localparam int DVS_W = XY_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef struct packed {
		logic load_start;
		logic setup;
		logic div_start;
		logic div_sel;
		logic inc_wr;
		logic init;
		logic emit;
		logic blank;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic div_done;
		logic out_ready;
	} sts_t;

endpackage

[rtl/vlw_div.sv]
// vlw_div: restoring divider, one quotient bit per cycle
// depends on vlw_pkg for operand widths
module vlw_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [vlw_pkg::DVD_W-1:0] dividend,
	input  logic [vlw_pkg::DVS_W-1:0] divisor,
	output logic [vlw_pkg::DVD_W-1:0] quotient,
	output logic                     done
);
	import vlw_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge = trial >= {1'b0, divisor};
	assign diff = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule

[rtl/vlw_ctrl.sv]
// vlw_ctrl: sequencer for line setup, the two minor-axis divisions and voxel output
// depends on vlw_pkg for cmd_t, sts_t and function codes
module vlw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          func,
	input  vlw_pkg::sts_t sts,
	output vlw_pkg::cmd_t cmd
);
	import vlw_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_GO_A   = 3'd2;
	localparam logic [2:0] ST_WAIT_A = 3'd3;
	localparam logic [2:0] ST_GO_B   = 3'd4;
	localparam logic [2:0] ST_WAIT_B = 3'd5;
	localparam logic [2:0] ST_INIT   = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = !(state_q == ST_IDLE && sts.out_ready);
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_START) begin
						cmd.load_start = 1'b1;
						state_d = ST_SETUP;
					end else if (sts.active) begin
						cmd.emit = 1'b1;
					end else begin
						cmd.blank = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = ST_GO_A;
			end
			ST_GO_A: begin
				cmd.div_start = 1'b1;
				state_d = ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (sts.div_done) begin
					cmd.inc_wr = 1'b1;
					state_d = ST_GO_B;
				end
			end
			ST_GO_B: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
				state_d = ST_WAIT_B;
			end
			ST_WAIT_B: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done) begin
					cmd.inc_wr = 1'b1;
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_ready) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/vlw_dpath.sv]
// vlw_dpath: walk state, setup arithmetic, dda step logic and output register
// depends on vlw_pkg and vlw_div
module vlw_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vlw_pkg::cmd_t           cmd,
	output vlw_pkg::sts_t           sts,
	input  logic [vlw_pkg::XY_W-1:0] start_x,
	input  logic [vlw_pkg::XY_W-1:0] start_y,
	input  logic [vlw_pkg::Z_W-1:0]  start_z,
	input  logic [vlw_pkg::XY_W-1:0] end_x,
	input  logic [vlw_pkg::XY_W-1:0] end_y,
	input  logic [vlw_pkg::Z_W-1:0]  end_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    valid_res,
	output logic [vlw_pkg::XY_W-1:0] vox_x,
	output logic [vlw_pkg::XY_W-1:0] vox_y,
	output logic [vlw_pkg::Z_W-1:0]  vox_z,
	output logic                    last
);
	import vlw_pkg::*;

	logic [XY_W-1:0]  pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
	logic [Z_W-1:0]   pos_z_q, tgt_z_q;
	logic [2:0]       sign_q;
	logic [XY_W-1:0]  mag_q [3];
	logic [1:0]       maj_q;
	logic [INC_W-1:0] inc_q [3];
	logic [ACC_W-1:0] acc_q [3];
	logic             active_q;

	logic             out_valid_q, res_valid_q, last_q;
	logic [XY_W-1:0]  vox_x_q, vox_y_q;
	logic [Z_W-1:0]   vox_z_q;
	logic             out_ready;

	// setup
	logic [2:0]       neg_d;
	logic [XY_W-1:0]  mag_d [3];
	logic [Z_W-1:0]   mag_z;
	logic [1:0]       maj_d;

	// division
	logic [1:0]       min_ax;
	logic [DVD_W-1:0] dividend;
	logic [DVD_W-1:0] quotient;
	logic             div_done;

	// step
	logic             at_end, sel_z, sel_x;
	logic [1:0]       mv_ax;
	logic             x_out, y_out, z_out, edge_out, fin;
	logic [XY_W-1:0]  nx, ny;
	logic [Z_W-1:0]   nz;
	logic [ACC_W-1:0] acc_add;
	logic [INC_W-1:0] init_inc [3];
	logic [INC_W-1:0] init_half [3];

	always_comb begin
		neg_d[0] = tgt_x_q < pos_x_q;
		neg_d[1] = tgt_y_q < pos_y_q;
		neg_d[2] = tgt_z_q < pos_z_q;
		mag_d[0] = neg_d[0] ? pos_x_q - tgt_x_q : tgt_x_q - pos_x_q;
		mag_d[1] = neg_d[1] ? pos_y_q - tgt_y_q : tgt_y_q - pos_y_q;
		mag_z = neg_d[2] ? pos_z_q - tgt_z_q : tgt_z_q - pos_z_q;
		mag_d[2] = XY_W'(mag_z);
		if (mag_d[0] >= mag_d[1] && mag_d[0] >= mag_d[2]) begin
			maj_d = AX_X;
		end else if (mag_d[1] >= mag_d[2]) begin
			maj_d = AX_Y;
		end else begin
			maj_d = AX_Z;
		end
	end

	// first pass takes the lower minor axis, second the upper one
	always_comb begin
		if (cmd.div_sel) begin
			min_ax = (maj_q == AX_Z) ? AX_Y : AX_Z;
		end else begin
			min_ax = (maj_q == AX_X) ? AX_Y : AX_X;
		end
	end

	assign dividend = {mag_q[maj_q], MAJ_SHIFT'(0)};

	vlw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (mag_q[min_ax]),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			init_inc[i] = (2'(i) == maj_q) ? MAJ_INC : inc_q[i];
			init_half[i] = init_inc[i] >> 1;
		end
	end

	// step: ties go to z, then y
	always_comb begin
		at_end = pos_x_q == tgt_x_q && pos_y_q == tgt_y_q && pos_z_q == tgt_z_q;
		sel_z = acc_q[2] <= acc_q[0] && acc_q[2] <= acc_q[1];
		sel_x = !sel_z && acc_q[0] < acc_q[1];
		if (sel_z) begin
			mv_ax = AX_Z;
		end else if (sel_x) begin
			mv_ax = AX_X;
		end else begin
			mv_ax = AX_Y;
		end
		x_out = sign_q[0] ? (pos_x_q == '0) : (32'(pos_x_q) + 32'd1 >= MAP_SIDE);
		y_out = sign_q[1] ? (pos_y_q == '0) : (32'(pos_y_q) + 32'd1 >= MAP_SIDE);
		z_out = sign_q[2] ? (pos_z_q == '0) : (32'(pos_z_q) + 32'd1 >= MAP_HEIGHT);
		nx = sign_q[0] ? pos_x_q - 1'b1 : pos_x_q + 1'b1;
		ny = sign_q[1] ? pos_y_q - 1'b1 : pos_y_q + 1'b1;
		nz = sign_q[2] ? pos_z_q - 1'b1 : pos_z_q + 1'b1;
		if (sel_z) begin
			edge_out = z_out;
		end else if (sel_x) begin
			edge_out = x_out;
		end else begin
			edge_out = y_out;
		end
		fin = at_end || edge_out;
		acc_add = acc_q[mv_ax] + ACC_W'(inc_q[mv_ax]);
	end

	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				active_q <= 1'b1;
			end else if (cmd.emit && fin) begin
				active_q <= 1'b0;
			end
			if (cmd.emit || cmd.blank) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			pos_x_q <= start_x;
			pos_y_q <= start_y;
			pos_z_q <= start_z;
			tgt_x_q <= end_x;
			tgt_y_q <= end_y;
			tgt_z_q <= end_z;
		end else if (cmd.emit && !fin) begin
			unique case (mv_ax)
				AX_X: pos_x_q <= nx;
				AX_Y: pos_y_q <= ny;
				default: pos_z_q <= nz;
			endcase
			acc_q[mv_ax] <= acc_add;
		end
		if (cmd.setup) begin
			sign_q <= neg_d;
			maj_q <= maj_d;
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_d[i];
			end
		end
		if (cmd.inc_wr) begin
			inc_q[min_ax] <= (mag_q[min_ax] == '0) ? ZERO_INC : INC_W'(quotient);
		end
		// accumulators start at half the increment, mirrored for forward runs
		if (cmd.init) begin
			for (int i = 0; i < 3; i++) begin
				inc_q[i] <= init_inc[i];
				acc_q[i] <= sign_q[i] ? ACC_W'(init_half[i])
					: ACC_W'(init_inc[i] - init_half[i]);
			end
		end
		if (cmd.emit) begin
			res_valid_q <= 1'b1;
			vox_x_q <= pos_x_q;
			vox_y_q <= pos_y_q;
			vox_z_q <= pos_z_q;
			last_q <= fin;
		end else if (cmd.blank) begin
			res_valid_q <= 1'b0;
			vox_x_q <= '0;
			vox_y_q <= '0;
			vox_z_q <= '0;
			last_q <= 1'b0;
		end
	end

	assign sts.active = active_q;
	assign sts.div_done = div_done;
	assign sts.out_ready = out_ready;

	assign out_valid = out_valid_q;
	assign valid_res = res_valid_q;
	assign vox_x = vox_x_q;
	assign vox_y = vox_y_q;
	assign vox_z = vox_z_q;
	assign last = last_q;

endmodule

[rtl/voxel_line_walk.sv]
// voxel_line_walk: top level of the 3-d dda voxel line walker
// depends on vlw_pkg, vlw_ctrl and vlw_dpath
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall   | func, start_x/y/z, end_x/y/z
//  out     | out_valid / out_stall | valid_res, vox_x/y/z, last
//
// a step request is taken and its voxel lands in the output register at the same
// edge, so steps stream while results are drained
// a start request is set up by two passes through the shared bit-serial divider
// for the minor-axis increments
// in_stall is high while a start is being set up and while a result waits stalled
// reset is asynchronous, active low, and needs no clearing pass
module voxel_line_walk (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic [vlw_pkg::XY_W-1:0] start_x,
	input  logic [vlw_pkg::XY_W-1:0] start_y,
	input  logic [vlw_pkg::Z_W-1:0]  start_z,
	input  logic [vlw_pkg::XY_W-1:0] end_x,
	input  logic [vlw_pkg::XY_W-1:0] end_y,
	input  logic [vlw_pkg::Z_W-1:0]  end_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    valid_res,
	output logic [vlw_pkg::XY_W-1:0] vox_x,
	output logic [vlw_pkg::XY_W-1:0] vox_y,
	output logic [vlw_pkg::Z_W-1:0]  vox_z,
	output logic                    last
);
	import vlw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vlw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	vlw_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.end_x     (end_x),
		.end_y     (end_y),
		.end_z     (end_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.vox_x     (vox_x),
		.vox_y     (vox_y),
		.vox_z     (vox_z),
		.last      (last)
	);

endmodule

[rtl/vlw_checker.sv]
// vlw_checker: port-level checks on the voxel line walker, bound to the top level
// depends on vlw_pkg for widths and function codes
module vlw_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    func,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic                    valid_res,
	input logic [vlw_pkg::XY_W-1:0] vox_x,
	input logic [vlw_pkg::XY_W-1:0] vox_y,
	input logic [vlw_pkg::Z_W-1:0]  vox_z,
	input logic                    last
);
	import vlw_pkg::*;

	logic in_take;

	assign in_take = in_valid && !in_stall;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(vox_x)
			&& $stable(vox_y) && $stable(vox_z) && $stable(last))
		else $error("stalled result changed");

	// a step with no line gives an all-zero result
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> vox_x == '0 && vox_y == '0 && vox_z == '0 && !last)
		else $error("empty result carries data");

	// a start request blocks the input while the line is set up
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && func == FUNC_START |=> in_stall)
		else $error("input open during line setup");

	// a step request has its result in the next cycle
	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && func == FUNC_STEP |=> out_valid)
		else $error("step result missing");

endmodule

bind voxel_line_walk vlw_checker u_vlw_checker (.*);
